>>> sv/tfce_pkg.sv
// Shared types, constants and helper functions for the time-frame character encoder.
`default_nettype none
package tfce_pkg;

	localparam int CHARS   = 14;
	localparam int NIB_W   = 4;
	localparam int WORD_W  = 6;
	localparam int CHAR_W  = 7;
	localparam int IDX_W   = 4;
	localparam int FRAME_W = 88;

	localparam logic [NIB_W-1:0] HDR_NIB     = 4'hF;
	localparam logic [NIB_W-1:0] DEP_FIX_NIB = 4'h6;
	localparam logic [NIB_W-1:0] DEP_END_NIB = 4'h5;
	localparam logic [NIB_W-1:0] TRL_HI_NIB  = 4'h2;
	localparam logic [NIB_W-1:0] TRL_LO_NIB  = 4'hD;
	localparam logic [NIB_W-1:0] CK_SEED     = 4'h7;
	// Seed 7 plus the fixed department nibbles 6 and 5.
	localparam logic [7:0]       DEP_CK_BASE = 8'd18;

	localparam logic [WORD_W-1:0] WORD_LOW_K = 6'd59;
	localparam logic [WORD_W-1:0] WORD_P     = 6'h20;
	localparam logic [WORD_W-1:0] WORD_S     = 6'h03;
	localparam logic [CHAR_W-1:0] CHAR_K     = 7'h6B;
	localparam logic [CHAR_W-1:0] CHAR_P     = 7'h70;
	localparam logic [CHAR_W-1:0] CHAR_S     = 7'h73;
	localparam logic [CHAR_W-1:0] CHAR_BIAS  = 7'h20;

	localparam logic [IDX_W-1:0] LAST_IDX = 4'(CHARS - 1);

	typedef logic [CHARS-1:0][CHAR_W-1:0] frame_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  idx;
	} cell_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Quotient by ten for 0..63: multiply by 13/128.
	function automatic logic [2:0] div10(input logic [5:0] v);
		logic [9:0] p;
		p = {4'b0, v} * 10'd13;
		return p[9:7];
	endfunction

	function automatic logic [CHAR_W-1:0] map_word(input logic [WORD_W-1:0] w);
		logic [CHAR_W-1:0] c;
		if (w >= WORD_LOW_K)
			c = CHAR_K + {1'b0, w - WORD_LOW_K};
		else if (w == WORD_P)
			c = CHAR_P;
		else if (w == WORD_S)
			c = CHAR_S;
		else
			c = {1'b0, w} + CHAR_BIAS;
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/tfce_ifs.sv
// Handshake channels: clock readings in, frame characters out.
`default_nettype none
interface tfce_reading_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [3:0] month;
	logic [4:0] day;
	logic [5:0] year_offset;
	logic [6:0] department;

	modport source (output valid, hour, minute, month, day, year_offset, department,
		input ready);
	modport sink (input valid, hour, minute, month, day, year_offset, department,
		output ready);
endinterface

interface tfce_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic [3:0] char_index;
	logic       last;

	modport source (output valid, char_code, char_index, last, input ready);
	modport sink (input valid, char_code, char_index, last, output ready);
endinterface
`default_nettype wire

>>> sv/tfce_frame_build.sv
// Builds the 22-nibble time frame and maps it to 14 characters.
`default_nettype none
module tfce_frame_build
	import tfce_pkg::*;
(
	input  wire logic [4:0] hour,
	input  wire logic [5:0] minute,
	input  wire logic [3:0] month,
	input  wire logic [4:0] day,
	input  wire logic [5:0] year_offset,
	input  wire logic [6:0] department,
	output frame_t          chars
);

	logic [2:0]         m10;
	logic [2:0]         d10;
	logic [5:0]         m10x;
	logic [5:0]         d10x;
	logic [NIB_W-1:0]   m1, d1;
	logic [4:0]         hour_m10;
	logic               hour_teen;
	logic [NIB_W-1:0]   nb1, nb2, nb5, nb6, nb7, ck;
	logic [NIB_W-1:0]   nb14, nb15, nb16;
	logic [7:0]         dck;
	logic [FRAME_W-1:0] frame;

	always_comb begin
		m10  = div10(minute);
		d10  = div10({1'b0, day});
		m10x = {3'b0, m10} * 6'd10;
		d10x = {3'b0, d10} * 6'd10;
		m1   = 4'(minute - m10x);
		d1   = 4'({1'b0, day} - d10x);

		// Fold the tens of the hour: teens add ten to the tens-of-minute digit.
		hour_m10  = hour - 5'd10;
		hour_teen = hour inside {[5'd10:5'd19]};
		nb1 = (hour < 5'd10) ? hour[3:0] : hour_m10[3:0];
		nb2 = {1'b0, m10} + (hour_teen ? 4'd10 : 4'd0);
		nb5 = {d10[1:0], d1[3:2]};
		nb6 = {d1[1:0], year_offset[5:4]};
		nb7 = year_offset[3:0];
		// Only the low nibble of the checksum survives, so sum modulo 16.
		ck  = CK_SEED + HDR_NIB + nb1 + nb2 + m1 + month + nb5 + nb6 + nb7;

		nb14 = {2'b01, department[6:5]};
		nb15 = department[4:1];
		nb16 = {department[0], 3'b000};
		dck  = DEP_CK_BASE + {4'b0, nb14} + {4'b0, nb15} + {4'b0, nb16};

		frame = {HDR_NIB, nb1, nb2, m1, month, nb5, nb6, nb7, ck,
			4'h0, 4'h0, 4'h0, DEP_FIX_NIB, 4'h0, nb14, nb15, nb16, DEP_END_NIB,
			dck, TRL_HI_NIB, TRL_LO_NIB};
	end

	for (genvar k = 0; k < CHARS; k++) begin : g_word
		assign chars[k] = map_word(frame[FRAME_W-1-WORD_W*k -: WORD_W]);
	end

endmodule
`default_nettype wire

>>> sv/tfce_cell.sv
// One cell of the output chain: holds a character and hands it to its neighbor.
`default_nettype none
module tfce_cell
	import tfce_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire cell_t     load_d,
	input  wire cell_t     next_d,
	output cell_t          cell_q
);

	always_ff @(posedge clk) begin
		if (ctl.load)
			cell_q <= load_d;
		else if (ctl.shift)
			cell_q <= next_d;
	end

endmodule
`default_nettype wire

>>> sv/time_frame_char_encoder.sv
// Top level: frame builder, one-frame holding register and a chain of character cells.
//
//  channel   dir  word                                      per frame
//  reading   in   hour minute month day year_offset dept    1 word
//  chars     out  char_code char_index last                 14 words
//
// One frame leaves as 14 characters, one per cycle while chars.ready is high,
// so at full rate a reading is taken once per frame. The chain of 14 cells sets
// that rate: it shifts one cell toward the output per accepted character.
// A reading is built in its accept cycle and held until the chain drains; the
// chain reloads in the cycle its last character is taken, so no gap appears.
// Reset clears the fill count and the holding flag; stalls on chars hold the chain.
`default_nettype none
module time_frame_char_encoder
	import tfce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	tfce_reading_if.sink   reading,
	tfce_char_if.source    chars
);

	frame_t     built;
	frame_t     frame_q;
	logic       full_q;
	logic [3:0] fill_q;
	logic       pop;
	logic       load;
	logic       take;
	cell_ctl_t  ctl;
	cell_t      cell_q [CHARS];
	cell_t      next_d [CHARS];
	cell_t      load_d [CHARS];

	tfce_frame_build u_build (
		.hour        (reading.hour),
		.minute      (reading.minute),
		.month       (reading.month),
		.day         (reading.day),
		.year_offset (reading.year_offset),
		.department  (reading.department),
		.chars       (built)
	);

	assign pop  = chars.valid && chars.ready;
	assign load = full_q && ((fill_q == 4'd0) || ((fill_q == 4'd1) && pop));
	assign take = reading.valid && reading.ready;
	assign reading.ready = !full_q || load;

	assign ctl.load  = load;
	assign ctl.shift = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			fill_q <= 4'd0;
		end else begin
			if (take)
				full_q <= 1'b1;
			else if (load)
				full_q <= 1'b0;
			if (load)
				fill_q <= 4'(CHARS);
			else if (pop)
				fill_q <= fill_q - 4'd1;
		end
	end

	// Hold the built frame until the chain is free.
	always_ff @(posedge clk) begin
		if (take)
			frame_q <= built;
	end

	for (genvar k = 0; k < CHARS; k++) begin : g_cell
		assign load_d[k].char_code = frame_q[k];
		assign load_d[k].idx       = 4'(k);
		if (k == CHARS - 1) begin : g_end
			assign next_d[k] = '0;
		end else begin : g_mid
			assign next_d[k] = cell_q[k+1];
		end
		tfce_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.load_d (load_d[k]),
			.next_d (next_d[k]),
			.cell_q (cell_q[k])
		);
	end

	assign chars.valid      = (fill_q != 4'd0);
	assign chars.char_code  = cell_q[0].char_code;
	assign chars.char_index = cell_q[0].idx;
	assign chars.last       = (cell_q[0].idx == LAST_IDX);

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && chars.last |-> fill_q == 4'd1)
		else $error("last character taken with more left in the chain");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !chars.last |=> chars.valid &&
			chars.char_index == $past(chars.char_index) + 4'd1)
		else $error("character index did not advance by one");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (fill_q == 4'd0) || (pop && chars.last))
		else $error("chain reloaded while characters remained");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> fill_q == 4'(CHARS) && chars.char_index == 4'd0)
		else $error("reload did not start a full frame at index zero");

endmodule
`default_nettype wire
